// File: hdl/swrl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sliding-window rate limiter.
// No dependencies; imported by the top level and the checker.
package swrl_pkg;

  localparam int ARRIVAL_BITS   = 48;
  localparam int COUNT_BITS     = 8;
  localparam int LIMIT_BITS     = 8;
  localparam int WINDOW_BITS    = 32;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 1;

  localparam int DEF_RING_DEPTH = 128;
  localparam int DEF_STAMP_BITS = 48;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t REG_MESSAGE_LIMIT = 1'd0;
  localparam cfg_index_t REG_WINDOW_TICKS  = 1'd1;

  localparam logic [LIMIT_BITS-1:0]  RESET_MESSAGE_LIMIT = 8'd100;
  localparam logic [WINDOW_BITS-1:0] RESET_WINDOW_TICKS  = 32'd1000000;

endpackage

// File: hdl/sliding_window_rate_limiter_unit.sv
`timescale 1ns / 1ps
// An arrival is registered while the oldest stamp is read; the scan state then drops
// expired stamps, the single age compare unit and the one-read ring port handling one held
// stamp per cycle, and loads the result once the output register is free. The next arrival
// is taken while the previous result waits in the output register, not during a scan.
// Reset (rst, sync, high): ring emptied, limit 100, window 1000000 ticks.
// Depends on swrl_pkg and swrl_ring.
module sliding_window_rate_limiter_unit #(
  parameter int RING_DEPTH = swrl_pkg::DEF_RING_DEPTH,
  parameter int STAMP_BITS = swrl_pkg::DEF_STAMP_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [swrl_pkg::ARRIVAL_BITS-1:0]    s_tdata,   // [47:0] arrival_time
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [swrl_pkg::COUNT_BITS-1:0]      m_tdata,   // [7:0] window_count
  output logic                                 m_tuser,   // [0] limited
  input  logic                                 cfg_we,
  input  swrl_pkg::cfg_index_t                 cfg_index,
  input  logic [swrl_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import swrl_pkg::*;

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int CMP_W = (STAMP_BITS > WINDOW_BITS) ? STAMP_BITS : WINDOW_BITS;

  typedef enum logic [0:0] {ST_IDLE, ST_SCAN} state_t;

  state_t                   state;
  logic [STAMP_BITS-1:0]    now;
  logic [IDX_W-1:0]         oldest;
  logic [CNT_W-1:0]         held;
  logic [LIMIT_BITS-1:0]    message_limit;
  logic [WINDOW_BITS-1:0]   window_ticks;

  logic                     accept;
  logic [STAMP_BITS-1:0]    stamp;
  logic [STAMP_BITS-1:0]    age;
  logic                     expired;
  logic                     pop;
  logic                     finish;
  logic                     over_limit;
  logic [31:0]              eff_limit;
  logic [IDX_W-1:0]         oldest_inc;
  logic [SUM_W-1:0]         slot_sum;
  logic [IDX_W-1:0]         wslot;
  logic                     ring_we;
  logic                     ring_re;
  logic [IDX_W-1:0]         raddr;
  logic [63:0]              arrival_ext;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign arrival_ext = 64'(s_tdata);

  // shared unit: modular age of the oldest held stamp against the window
  assign age     = now - stamp;
  assign expired = (held != '0) && (CMP_W'(age) >= CMP_W'(window_ticks));

  assign pop    = (state == ST_SCAN) && expired;
  assign finish = (state == ST_SCAN) && !expired && (!m_tvalid || m_tready);

  assign eff_limit  = (32'(message_limit) > 32'(RING_DEPTH)) ? 32'(RING_DEPTH)
                                                             : 32'(message_limit);
  assign over_limit = 32'(held) >= eff_limit;

  assign oldest_inc = (oldest == IDX_W'(RING_DEPTH - 1)) ? '0 : oldest + 1'b1;
  assign slot_sum   = SUM_W'(oldest) + SUM_W'(held);
  assign wslot      = (slot_sum >= SUM_W'(RING_DEPTH)) ? IDX_W'(slot_sum - SUM_W'(RING_DEPTH))
                                                       : IDX_W'(slot_sum);

  assign ring_we = finish && !over_limit;
  // while scanning, prefetch the stamp after the one being dropped
  assign ring_re = accept || pop;
  assign raddr   = (state == ST_SCAN) ? oldest_inc : oldest;

  swrl_ring #(
    .DEPTH (RING_DEPTH),
    .WIDTH (STAMP_BITS)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (wslot),
    .wdata (now),
    .re    (ring_re),
    .raddr (raddr),
    .rdata (stamp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      oldest        <= '0;
      held          <= '0;
      message_limit <= RESET_MESSAGE_LIMIT;
      window_ticks  <= RESET_WINDOW_TICKS;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MESSAGE_LIMIT: message_limit <= cfg_data[LIMIT_BITS-1:0];
          REG_WINDOW_TICKS:  window_ticks  <= cfg_data[WINDOW_BITS-1:0];
          default: ;
        endcase
      end

      // a new beat loaded in the same cycle keeps valid high
      if (m_tvalid && m_tready && !finish) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            now   <= arrival_ext[STAMP_BITS-1:0];
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (pop) begin
            oldest <= oldest_inc;
            held   <= held - 1'b1;
          end else if (finish) begin
            m_tvalid <= 1'b1;
            m_tuser  <= over_limit;
            if (over_limit) begin
              m_tdata <= COUNT_BITS'(held);
            end else begin
              held    <= held + 1'b1;
              m_tdata <= COUNT_BITS'(held + 1'b1);
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/swrl_ring.sv
`timescale 1ns / 1ps
// Timestamp ring storage: one write port, one read port, registered read data.
// No package dependencies.
module swrl_ring #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/swrl_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the rate limiter, bound to the top level.
// Depends on swrl_pkg.
module swrl_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic [swrl_pkg::ARRIVAL_BITS-1:0]  s_tdata,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [swrl_pkg::COUNT_BITS-1:0]    m_tdata,
  input logic                               m_tuser
);
  import swrl_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // an accepted arrival always moves the unit into a scan, during which input is not ready
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after an accepted beat");

  // a fresh result only comes out of a scan cycle
  a_result_from_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared without a scan");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("bad state after reset");

endmodule

bind sliding_window_rate_limiter_unit swrl_checker u_swrl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
